// File: rtl/alm_pkg.sv
// Shared widths, constants, register indexes and control types of the audio level meter.
package alm_pkg;

  localparam int SMP_W     = 25;
  localparam int LVL_W     = 16;
  localparam int A0_W      = 47;
  localparam int COEF_W    = 48;
  localparam int DEC_W     = 16;
  localparam int OFS_W     = 12;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int X_W       = 49;
  localparam int XS_W      = 51;
  localparam int Y_W       = 64;
  localparam int ACC_W     = 116;
  localparam int ACC_SHIFT = 46;
  localparam int Q_W       = ACC_W - ACC_SHIFT;
  localparam int LOG_W     = 64;
  localparam int MANT_W    = 31;
  localparam int FRAC_W    = 16;
  localparam int NRM_W     = 6;
  localparam int LQ_W      = NRM_W + FRAC_W + 1;
  localparam int K_W       = 19;
  localparam int DBP_W     = 43;
  localparam int DB_SHIFT  = 24;
  localparam int HELD_W    = 32;
  localparam int BIT_W     = 6;
  localparam int ITER_W    = 4;

  localparam int MAX_BLOCK_DEF = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_A0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd4;

  localparam logic [DEC_W-1:0]        DECAY_RST  = 16'd3030;
  localparam logic signed [OFS_W-1:0] OFFSET_RST = 12'sd358;

  localparam logic [1:0] TERM_FF = 2'd0;
  localparam logic [1:0] TERM_B1 = 2'd1;
  localparam logic [1:0] TERM_B2 = 2'd2;

  localparam logic [SMP_W-1:0]         ONE_FS   = 25'd8388608;
  localparam logic [K_W-1:0]           K_PWR    = 19'd197283;
  localparam logic [K_W-1:0]           K_AMP    = 19'd394566;
  localparam logic signed [LQ_W-1:0]   E_PWR    = 23'sd3014656;
  localparam logic signed [LQ_W-1:0]   E_AMP    = 23'sd1507328;
  localparam logic signed [LVL_W-1:0]  LVL_MIN  = 16'sh8000;
  localparam logic signed [LVL_W-1:0]  LVL_MAX  = 16'sh7fff;
  localparam logic signed [HELD_W-1:0] HELD_MIN = 32'sh80000000;
  localparam logic signed [Y_W-1:0]    Y_MIN    = 64'sh8000000000000000;
  localparam logic signed [Y_W-1:0]    Y_MAX    = 64'sh7fffffffffffffff;

  typedef struct packed {
    logic       accept;
    logic       sq;
    logic       mac_load;
    logic [1:0] term;
    logic       mac_step;
    logic       mac_msb;
    logic       sat;
    logic       rms_floor;
    logic       log_load;
    logic       log_sel;
    logic       norm_step;
    logic       mant_load;
    logic       iter_step;
    logic       db_mul;
    logic       db_fin;
    logic       bp_floor;
    logic       peak_mul;
    logic       peak_fin;
    logic       out_load;
  } alm_cmd_t;

  typedef struct packed {
    logic y_pos;
    logic norm_done;
    logic end_flag;
    logic bpm_nz;
  } alm_stat_t;

endpackage

// File: rtl/alm_datapath.sv
// Datapath: bit-serial lowpass MAC, iterative log2, dB scaling, peak hold and overs.
module alm_datapath import alm_pkg::*; #(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_wdata,
  input  logic signed [SMP_W-1:0]     in_sample,
  input  logic                        in_block_end,
  input  alm_cmd_t                    cmd_i,
  output alm_stat_t                   stat_o,
  output logic signed [LVL_W-1:0]     out_rms_level,
  output logic signed [LVL_W-1:0]     out_peak_level,
  output logic signed [LVL_W-1:0]     out_max_peak_level,
  output logic [LVL_W-1:0]            out_over_count
);

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int DPR_W = CNT_W + DEC_W;
  localparam int DIF_W = ((DPR_W > HELD_W) ? DPR_W : HELD_W) + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCK);
  localparam logic signed [DIF_W-1:0] HMIN_EXT = DIF_W'(HELD_MIN);

  logic [A0_W-1:0]          a0_r;
  logic signed [COEF_W-1:0] b1_r, b2_r;
  logic [DEC_W-1:0]         decay_r;
  logic signed [OFS_W-1:0]  ofs_r;

  logic signed [SMP_W-1:0]  smp_r;
  logic                     end_r;
  logic [X_W-1:0]           x0_r, x1_r, x2_r;
  logic signed [Y_W-1:0]    y0_r, y1_r, y2_r;
  logic signed [ACC_W-1:0]  acc_r, op_r;
  logic [COEF_W-1:0]        cf_r;
  logic [LOG_W-1:0]         lv_r;
  logic [NRM_W-1:0]         ln_r;
  logic [MANT_W-1:0]        lm_r;
  logic [FRAC_W-1:0]        lf_r;
  logic signed [DBP_W-1:0]  dbp_r;
  logic signed [LVL_W-1:0]  rms_r, bp_r, maxp_r;
  logic [SMP_W-1:0]         bpm_r;
  logic [CNT_W-1:0]         cnt_r;
  logic signed [HELD_W-1:0] held_r;
  logic [1:0]               clip_r;
  logic [LVL_W-1:0]         overs_r;
  logic [DPR_W-1:0]         dpr_r;

  logic [SMP_W-1:0]         mag;
  logic [2*SMP_W-1:0]       sq_full;
  logic [XS_W-1:0]          xs;
  logic signed [Q_W-1:0]    q;
  logic signed [Y_W-1:0]    y_sat;
  logic [2*MANT_W-1:0]      msq;
  logic [MANT_W:0]          mt;
  logic signed [LQ_W-1:0]   lsub;
  logic [K_W-1:0]           kk;
  logic signed [DBP_W-1:0]  dbp_nxt;
  logic signed [LQ_W-5:0]   dq;
  logic signed [LVL_W-1:0]  dbc;
  logic signed [LVL_W:0]    rsum;
  logic signed [LVL_W-1:0]  rms_nxt;
  logic signed [DIF_W-1:0]  dif;
  logic signed [HELD_W-1:0] hcl, bph, held_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a0_r    <= '0;
      b1_r    <= '0;
      b2_r    <= '0;
      decay_r <= DECAY_RST;
      ofs_r   <= OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_A0:     a0_r    <= cfg_wdata[A0_W-1:0];
        REG_B1:     b1_r    <= cfg_wdata[COEF_W-1:0];
        REG_B2:     b2_r    <= cfg_wdata[COEF_W-1:0];
        REG_DECAY:  decay_r <= cfg_wdata[DEC_W-1:0];
        REG_OFFSET: ofs_r   <= cfg_wdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  assign mag     = in_sample[SMP_W-1] ? SMP_W'(-in_sample) : SMP_W'(in_sample);
  assign sq_full = $unsigned((2*SMP_W)'(smp_r) * (2*SMP_W)'(smp_r));
  assign xs      = XS_W'(x0_r) + XS_W'({x1_r, 1'b0}) + XS_W'(x2_r);

  assign q     = acc_r[ACC_W-1:ACC_SHIFT];
  assign y_sat = ((&q[Q_W-1:Y_W-1]) || !(|q[Q_W-1:Y_W-1])) ? q[Y_W-1:0]
               : (q[Q_W-1] ? Y_MIN : Y_MAX);

  assign msq  = (2*MANT_W)'(lm_r) * (2*MANT_W)'(lm_r);
  assign mt   = msq[2*MANT_W-1:MANT_W-1];
  assign lsub = $signed({1'b0, NRM_W'(6'd63 - ln_r), lf_r}) - (cmd_i.log_sel ? E_AMP : E_PWR);
  assign kk   = cmd_i.log_sel ? K_AMP : K_PWR;
  assign dbp_nxt = DBP_W'(lsub) * DBP_W'($signed({1'b0, kk}));

  assign dq   = dbp_r[DBP_W-1:DB_SHIFT];
  assign dbc  = (dq < $signed((LQ_W-4)'(LVL_MIN))) ? LVL_MIN : dq[LVL_W-1:0];
  assign rsum = (LVL_W+1)'(dbc) + (LVL_W+1)'(ofs_r);
  assign rms_nxt = (rsum < $signed((LVL_W+1)'(LVL_MIN))) ? LVL_MIN
                 : (rsum > $signed((LVL_W+1)'(LVL_MAX))) ? LVL_MAX : rsum[LVL_W-1:0];

  assign dif      = DIF_W'(held_r) - $signed(DIF_W'(dpr_r));
  assign hcl      = (dif < HMIN_EXT) ? HELD_MIN : dif[HELD_W-1:0];
  assign bph      = {bp_r, 16'b0};
  assign held_nxt = (bph > hcl) ? bph : hcl;

  always_ff @(posedge clk) begin
    if (cmd_i.accept) begin
      smp_r <= in_sample;
      end_r <= in_block_end;
    end
    if (cmd_i.sq) x0_r <= sq_full[X_W-1:0];
    if (cmd_i.mac_load) begin
      case (cmd_i.term)
        TERM_FF: begin
          op_r  <= ACC_W'(xs);
          cf_r  <= {1'b0, a0_r};
          acc_r <= '0;
        end
        TERM_B1: begin
          op_r <= -(ACC_W'(y1_r));
          cf_r <= b1_r;
        end
        default: begin
          op_r <= -(ACC_W'(y2_r));
          cf_r <= b2_r;
        end
      endcase
    end
    if (cmd_i.mac_step) begin
      if (cf_r[0]) acc_r <= cmd_i.mac_msb ? acc_r - op_r : acc_r + op_r;
      op_r <= op_r <<< 1;
      cf_r <= cf_r >> 1;
    end
    if (cmd_i.sat) y0_r <= y_sat;
    if (cmd_i.log_load) begin
      lv_r <= cmd_i.log_sel ? LOG_W'(bpm_r) : y0_r;
      ln_r <= '0;
    end
    if (cmd_i.norm_step) begin
      lv_r <= lv_r << 1;
      ln_r <= ln_r + 1'b1;
    end
    if (cmd_i.mant_load) begin
      lm_r <= lv_r[LOG_W-1:LOG_W-MANT_W];
      lf_r <= '0;
    end
    if (cmd_i.iter_step) begin
      lm_r <= mt[MANT_W] ? mt[MANT_W:1] : mt[MANT_W-1:0];
      lf_r <= {lf_r[FRAC_W-2:0], mt[MANT_W]};
    end
    if (cmd_i.db_mul) dbp_r <= dbp_nxt;
    if (cmd_i.db_fin && cmd_i.log_sel) bp_r <= dbc;
    if (cmd_i.bp_floor) bp_r <= LVL_MIN;
    if (cmd_i.peak_mul) dpr_r <= DPR_W'(cnt_r) * DPR_W'(decay_r);
    if (cmd_i.out_load) begin
      out_rms_level      <= rms_r;
      out_peak_level     <= held_r[HELD_W-1:HELD_W-LVL_W];
      out_max_peak_level <= maxp_r;
      out_over_count     <= overs_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r    <= '0;
      x2_r    <= '0;
      y1_r    <= '0;
      y2_r    <= '0;
      rms_r   <= LVL_MIN;
      bpm_r   <= '0;
      cnt_r   <= '0;
      held_r  <= HELD_MIN;
      maxp_r  <= LVL_MIN;
      clip_r  <= '0;
      overs_r <= '0;
    end else begin
      if (cmd_i.accept) begin
        if (mag >= ONE_FS) begin
          if (clip_r != 2'd3) begin
            clip_r <= clip_r + 1'b1;
            if (clip_r == 2'd2 && overs_r != '1) overs_r <= overs_r + 1'b1;
          end
        end else begin
          clip_r <= '0;
        end
        if (mag > bpm_r) bpm_r <= mag;
        if (cnt_r < CNT_MAX) cnt_r <= cnt_r + 1'b1;
      end
      if (cmd_i.sat) begin
        x2_r <= x1_r;
        x1_r <= x0_r;
        y2_r <= y1_r;
        y1_r <= y_sat;
      end
      if (cmd_i.rms_floor) rms_r <= LVL_MIN;
      if (cmd_i.db_fin && !cmd_i.log_sel) rms_r <= rms_nxt;
      if (cmd_i.peak_fin) begin
        held_r <= held_nxt;
        if ($signed(held_nxt[HELD_W-1:HELD_W-LVL_W]) > maxp_r)
          maxp_r <= held_nxt[HELD_W-1:HELD_W-LVL_W];
        bpm_r  <= '0;
        cnt_r  <= '0;
        clip_r <= '0;
      end
    end
  end

  assign stat_o.y_pos     = !y0_r[Y_W-1] && (|y0_r);
  assign stat_o.norm_done = lv_r[LOG_W-1];
  assign stat_o.end_flag  = end_r;
  assign stat_o.bpm_nz    = |bpm_r;

endmodule

// File: rtl/alm_ctrl.sv
// Controller: sequences the MAC, log and peak steps for one transaction.
module alm_ctrl import alm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  alm_stat_t stat_i,
  output alm_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_MACL = 4'd2;
  localparam logic [3:0] S_MACS = 4'd3;
  localparam logic [3:0] S_SAT  = 4'd4;
  localparam logic [3:0] S_RCHK = 4'd5;
  localparam logic [3:0] S_NORM = 4'd6;
  localparam logic [3:0] S_ITER = 4'd7;
  localparam logic [3:0] S_DBM  = 4'd8;
  localparam logic [3:0] S_DBF  = 4'd9;
  localparam logic [3:0] S_PCHK = 4'd10;
  localparam logic [3:0] S_PMUL = 4'd11;
  localparam logic [3:0] S_PFIN = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  localparam logic [BIT_W-1:0]  BIT_LAST  = BIT_W'(COEF_W - 1);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(FRAC_W - 1);

  logic [3:0]        state_r, state_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [1:0]        term_r, term_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              sel_r, sel_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    bit_nxt   = bit_r;
    term_nxt  = term_r;
    iter_nxt  = iter_r;
    sel_nxt   = sel_r;
    cmd_o     = '0;
    cmd_o.term    = term_r;
    cmd_o.log_sel = sel_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.accept = 1'b1;
          state_nxt    = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.sq  = 1'b1;
        term_nxt  = TERM_FF;
        state_nxt = S_MACL;
      end
      S_MACL: begin
        cmd_o.mac_load = 1'b1;
        bit_nxt        = '0;
        state_nxt      = S_MACS;
      end
      S_MACS: begin
        cmd_o.mac_step = 1'b1;
        cmd_o.mac_msb  = (bit_r == BIT_LAST);
        bit_nxt        = bit_r + 1'b1;
        if (bit_r == BIT_LAST) begin
          if (term_r == TERM_B2) begin
            state_nxt = S_SAT;
          end else begin
            term_nxt  = term_r + 1'b1;
            state_nxt = S_MACL;
          end
        end
      end
      S_SAT: begin
        cmd_o.sat = 1'b1;
        state_nxt = S_RCHK;
      end
      S_RCHK: begin
        if (stat_i.y_pos) begin
          cmd_o.log_load = 1'b1;
          cmd_o.log_sel  = 1'b0;
          sel_nxt        = 1'b0;
          state_nxt      = S_NORM;
        end else begin
          cmd_o.rms_floor = 1'b1;
          state_nxt       = S_PCHK;
        end
      end
      S_NORM: begin
        if (stat_i.norm_done) begin
          cmd_o.mant_load = 1'b1;
          iter_nxt        = '0;
          state_nxt       = S_ITER;
        end else begin
          cmd_o.norm_step = 1'b1;
        end
      end
      S_ITER: begin
        cmd_o.iter_step = 1'b1;
        iter_nxt        = iter_r + 1'b1;
        if (iter_r == ITER_LAST) state_nxt = S_DBM;
      end
      S_DBM: begin
        cmd_o.db_mul = 1'b1;
        state_nxt    = S_DBF;
      end
      S_DBF: begin
        cmd_o.db_fin = 1'b1;
        state_nxt    = sel_r ? S_PMUL : S_PCHK;
      end
      S_PCHK: begin
        if (!stat_i.end_flag) begin
          state_nxt = S_DONE;
        end else if (stat_i.bpm_nz) begin
          cmd_o.log_load = 1'b1;
          cmd_o.log_sel  = 1'b1;
          sel_nxt        = 1'b1;
          state_nxt      = S_NORM;
        end else begin
          cmd_o.bp_floor = 1'b1;
          state_nxt      = S_PMUL;
        end
      end
      S_PMUL: begin
        cmd_o.peak_mul = 1'b1;
        state_nxt      = S_PFIN;
      end
      S_PFIN: begin
        cmd_o.peak_fin = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd_o.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bit_r       <= '0;
      term_r      <= TERM_FF;
      iter_r      <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_r       <= bit_nxt;
      term_r      <= term_nxt;
      iter_r      <= iter_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.out_load |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while pending");

  a_mac_to_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MACS && bit_r == BIT_LAST && term_r == TERM_B2) |=> state_r == S_SAT)
    else $error("MAC did not finish after last term");

  a_norm_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NORM && stat_i.norm_done) |=> (state_r == S_ITER && iter_r == '0))
    else $error("normalizer exit lost");

  a_peak_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.peak_fin |-> stat_i.end_flag)
    else $error("peak update without block end");

endmodule

// File: rtl/audio_level_meter.sv
// Top level of the audio level meter: RMS, held peak, max peak and overs per sample.
// The bit-serial filter MAC (3 terms) and the one-bit-per-cycle log normalizer (up to 63
// shifts per log, two logs at a block end) set the time from acceptance to result: shortest
// when the RMS floors and no block ends, longest when both logs run.
// Throughput: one transaction at a time; the next is accepted once the result is queued.
// Reset: synchronous, active low; filter state clears, levels read -128 dB.
module audio_level_meter import alm_pkg::*; #(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [SMP_W-1:0] in_sample,
  input  logic                    in_block_end,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [LVL_W-1:0] out_rms_level,
  output logic signed [LVL_W-1:0] out_peak_level,
  output logic signed [LVL_W-1:0] out_max_peak_level,
  output logic [LVL_W-1:0]        out_over_count
);

  alm_cmd_t  cmd;
  alm_stat_t stat;

  alm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  alm_datapath #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_sample          (in_sample),
    .in_block_end       (in_block_end),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .out_rms_level      (out_rms_level),
    .out_peak_level     (out_peak_level),
    .out_max_peak_level (out_max_peak_level),
    .out_over_count     (out_over_count)
  );

endmodule

// File: tb/tb_audio_level_meter.sv
// Self-checking testbench for the audio level meter: RMS, held peak, max peak and overs.
`timescale 1ns / 1ps

module tb_audio_level_meter;
  import alm_pkg::*;

  typedef struct {
    logic signed [LVL_W-1:0] rms;
    logic signed [LVL_W-1:0] peak;
    logic signed [LVL_W-1:0] max_peak;
    logic [LVL_W-1:0]        overs;
  } levels_t;

  localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]        cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [SMP_W-1:0] in_sample = '0;
  logic                    in_block_end = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [LVL_W-1:0] out_rms_level;
  logic signed [LVL_W-1:0] out_peak_level;
  logic signed [LVL_W-1:0] out_max_peak_level;
  logic [LVL_W-1:0]        out_over_count;

  audio_level_meter dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample(in_sample), .in_block_end(in_block_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_rms_level(out_rms_level), .out_peak_level(out_peak_level),
    .out_max_peak_level(out_max_peak_level), .out_over_count(out_over_count)
  );

  always #5 clk = ~clk;

  // meter model state
  logic [A0_W-1:0]          m_a0;
  logic signed [COEF_W-1:0] m_b1, m_b2;
  logic [DEC_W-1:0]         m_decay;
  logic signed [OFS_W-1:0]  m_offset;
  logic [X_W-1:0]           m_x1, m_x2;
  logic signed [Y_W-1:0]    m_y1, m_y2;
  logic signed [LVL_W-1:0]  m_rms;
  logic [SMP_W-1:0]         m_blk_peak;
  int                       m_blk_count;
  longint                   m_held;
  logic signed [LVL_W-1:0]  m_max_peak;
  int                       m_clip_run;
  int                       m_overs;

  levels_t expected_levels[$];
  int n_sent = 0, n_checked = 0, n_mismatch = 0;
  int stall_pct = 0, gap_pct = 0, hold_cnt = 0;

  function automatic longint log2_q16(logic [63:0] v);
    int p;
    logic [63:0] m;
    longint frac;
    p = 63;
    frac = 0;
    while (p > 0 && !v[p]) p--;
    m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
    for (int i = 0; i < FRAC_W; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'(p) * 65536 + frac;
  endfunction

  function automatic longint level_db(logic [63:0] v, longint e, longint k);
    longint d;
    d = ((log2_q16(v) - e * 65536) * k) >>> DB_SHIFT;
    return (d < -32768) ? -32768 : d;
  endfunction

  function automatic void meter_reset();
    m_a0 = '0; m_b1 = '0; m_b2 = '0;
    m_decay = DECAY_RST; m_offset = OFFSET_RST;
    m_x1 = '0; m_x2 = '0; m_y1 = '0; m_y2 = '0;
    m_rms = LVL_MIN; m_blk_peak = '0; m_blk_count = 0;
    m_held = -64'sd2147483648; m_max_peak = LVL_MIN;
    m_clip_run = 0; m_overs = 0;
  endfunction

  function automatic levels_t meter_step(logic signed [SMP_W-1:0] s, logic blk_end);
    levels_t r;
    logic signed [127:0] acc, q;
    logic [X_W-1:0] x0;
    logic [SMP_W-1:0] mag;
    logic signed [Y_W-1:0] y0;
    longint d, bp;
    x0 = X_W'(longint'(s) * longint'(s));
    mag = (s < 0) ? SMP_W'(-longint'(s)) : SMP_W'(s);
    acc = $signed({81'b0, m_a0}) * $signed({79'b0, x0})
        + $signed({81'b0, m_a0}) * $signed({78'b0, m_x1, 1'b0})
        + $signed({81'b0, m_a0}) * $signed({79'b0, m_x2})
        - $signed({{80{m_b1[47]}}, m_b1}) * $signed({{64{m_y1[63]}}, m_y1})
        - $signed({{80{m_b2[47]}}, m_b2}) * $signed({{64{m_y2[63]}}, m_y2});
    q = acc >>> ACC_SHIFT;
    if (q > $signed({{64{1'b0}}, Y_MAX})) y0 = Y_MAX;
    else if (q < $signed({{64{1'b1}}, Y_MIN})) y0 = Y_MIN;
    else y0 = q[63:0];
    if (y0 <= 0) begin
      m_rms = LVL_MIN;
    end else begin
      d = level_db(y0, 46, 197283) + longint'(m_offset);
      if (d < -32768) d = -32768;
      if (d > 32767) d = 32767;
      m_rms = d[15:0];
    end
    m_x2 = m_x1; m_x1 = x0; m_y2 = m_y1; m_y1 = y0;
    if (mag >= ONE_FS) begin
      if (m_clip_run < 3) begin
        m_clip_run++;
        if (m_clip_run == 3 && m_overs < 65535) m_overs++;
      end
    end else begin
      m_clip_run = 0;
    end
    if (mag > m_blk_peak) m_blk_peak = mag;
    if (m_blk_count < MAX_BLOCK_DEF) m_blk_count++;
    if (blk_end) begin
      bp = (m_blk_peak == 0) ? -32768 : level_db(64'(m_blk_peak), 23, 394566);
      m_held -= longint'(m_blk_count) * longint'(m_decay);
      if (m_held < -64'sd2147483648) m_held = -64'sd2147483648;
      if (bp * 65536 > m_held) m_held = bp * 65536;
      if ((m_held >>> 16) > longint'(m_max_peak)) m_max_peak = 16'(m_held >>> 16);
      m_blk_peak = '0; m_blk_count = 0; m_clip_run = 0;
    end
    r.rms = m_rms;
    r.peak = 16'(m_held >>> 16);
    r.max_peak = m_max_peak;
    r.overs = 16'(m_overs);
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    levels_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_levels.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected transaction: rms %0d", out_rms_level);
      end else begin
        e = expected_levels.pop_front();
        n_checked++;
        if (e.rms !== out_rms_level || e.peak !== out_peak_level ||
            e.max_peak !== out_max_peak_level || e.overs !== out_over_count) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch #%0d: exp rms %0d peak %0d max %0d overs %0d, got %0d %0d %0d %0d",
                     n_checked, e.rms, e.peak, e.max_peak, e.overs, out_rms_level,
                     out_peak_level, out_max_peak_level, out_over_count);
        end
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_stall = 1'b1;
      hold_cnt--;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall = 1'b1;
      if ($urandom_range(99) < 4) hold_cnt = $urandom_range(60, 20);
    end else begin
      out_stall = 1'b0;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_A0:     m_a0 = val[A0_W-1:0];
      REG_B1:     m_b1 = val[COEF_W-1:0];
      REG_B2:     m_b2 = val[COEF_W-1:0];
      REG_DECAY:  m_decay = val[DEC_W-1:0];
      REG_OFFSET: m_offset = val[OFS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(logic signed [SMP_W-1:0] s, logic blk_end);
    int gap;
    @(negedge clk);
    in_valid = 1'b1; in_sample = s; in_block_end = blk_end;
    do @(posedge clk); while (in_stall);
    expected_levels.push_back(meter_step(s, blk_end));
    n_sent++;
    @(negedge clk);
    in_valid = 1'b0;
    if ($urandom_range(99) < gap_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(80, 20) : $urandom_range(3, 1);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic logic signed [SMP_W-1:0] rand_sample();
    case ($urandom_range(4))
      0: return SMP_W'($urandom);
      1: return SMP_W'($signed(SMP_W'($urandom_range(255))) - 128);
      2: return $urandom_range(1) ? 25'sd8388608 + SMP_W'($urandom_range(8388607))
                                  : -25'sd8388608 - SMP_W'($urandom_range(8388608));
      default: return SMP_W'($signed(SMP_W'($urandom_range(1048575))) - 524288);
    endcase
  endfunction

  task automatic program_lowpass();
    write_reg(REG_A0, 48'd70368744);
    write_reg(REG_B1, -48'sd140000000000000);
    write_reg(REG_B2, 48'sd69700000000000);
  endtask

  task automatic meter_reset_regs();
    program_lowpass();
    write_reg(REG_OFFSET, 48'd358);
  endtask

  task automatic test_idle_levels();
    send_sample(25'sd0, 1'b0);
    send_sample(25'sd1, 1'b0);
    send_sample(25'sd0, 1'b1);
    drain();
  endtask

  task automatic test_directed();
    program_lowpass();
    send_sample(25'sd16777215, 1'b0);
    send_sample(-25'sd16777216, 1'b0);
    send_sample(25'sd8388608, 1'b0);
    send_sample(-25'sd1, 1'b1);
    for (int i = 0; i < 4; i++) send_sample(-25'sd8388608, 1'b0);
    send_sample(25'sd8388607, 1'b0);
    for (int i = 0; i < 3; i++) send_sample(25'sd8388608, i == 2);
    send_sample(25'sd0, 1'b1);
    send_sample(25'sd1, 1'b1);
    drain();
    write_reg(REG_OFFSET, 48'hFFFF_FFFF_F800);
    write_reg(REG_DECAY, 48'd65535);
    write_reg(REG_NONE_LO, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_NONE_HI, 48'h0);
    send_sample(25'sd100, 1'b0);
    send_sample(25'sd3, 1'b1);
    drain();
    write_reg(REG_A0, 48'h7FFF_FFFF_FFFF);
    write_reg(REG_B1, 48'h7FFF_FFFF_FFFF);
    write_reg(REG_B2, 48'h8000_0000_0000);
    write_reg(REG_OFFSET, 48'd2047);
    for (int i = 0; i < 5; i++) send_sample(-25'sd16777216, 1'b0);
    send_sample(25'sd16777215, 1'b1);
    drain();
  endtask

  task automatic test_long_block();
    meter_reset_regs();
    write_reg(REG_DECAY, 48'd1);
    for (int i = 0; i < 250; i++) send_sample(rand_sample(), i == 249);
    send_sample(25'sd5, 1'b1);
    drain();
  endtask

  task automatic test_backpressure();
    stall_pct = 0; gap_pct = 0;
    @(posedge clk);
    hold_cnt = 600;
    for (int i = 0; i < 8; i++) send_sample(rand_sample(), i == 7);
    drain();
  endtask

  task automatic test_random_blocks();
    int len;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: begin stall_pct = 30; gap_pct = 30; end
        1: begin stall_pct = 0;  gap_pct = 0;  end
        default: begin stall_pct = 60; gap_pct = 60; end
      endcase
      if (phase == 0) meter_reset_regs();
      else if (phase == 3) begin
        write_reg(REG_A0, 48'($urandom) << 16 | 48'($urandom_range(65535)));
        write_reg(REG_B1, {$urandom, 16'($urandom)});
        write_reg(REG_B2, {$urandom, 16'($urandom)});
      end else if (phase == 4) begin
        program_lowpass();
      end
      write_reg(REG_DECAY, 48'($urandom_range(65535)));
      write_reg(REG_OFFSET, 48'($urandom));
      for (int b = 0; b < 12; b++) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(40, 20) : $urandom_range(16, 1);
        for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
      end
      drain();
    end
    stall_pct = 0; gap_pct = 0;
  endtask

  initial begin
    meter_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_idle_levels();
    test_directed();
    test_backpressure();
    test_random_blocks();
    test_long_block();
    drain();
    $display("Ran %0d samples through extreme and random filter, decay and offset settings,",
             n_sent);
    $display("including clip runs, block ends, a long block and output hold-off.");
    if (n_mismatch == 0 && expected_levels.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/alm_pkg.sv
rtl/alm_datapath.sv
rtl/alm_ctrl.sv
rtl/audio_level_meter.sv
tb/tb_audio_level_meter.sv
